FILE: hw/rtl/path_table_record_parser_core_defines.svh
// assertion macros shared by the path table record parser
`ifndef PATH_TABLE_RECORD_PARSER_CORE_DEFINES_SVH
`define PATH_TABLE_RECORD_PARSER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define PTRP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ptrp assertion failed");

`define PTRP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("ptrp assertion failed");

`else

`define PTRP_ASSERT(label, clk, rst, prop)

`define PTRP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: hw/rtl/ptrp_pkg.sv
// types and constants of the path table record parser
`timescale 1ns / 1ps
`default_nettype none

package ptrp_pkg;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_NAME   = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [7:0]  END_BYTE   = 8'h00;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   localparam logic [1:0] EXTENT_LAST = 2'd3;
   localparam logic [1:0] PARENT_LAST = 2'd1;

   typedef enum logic [6:0] {
      PH_LEN    = 7'b0000001,
      PH_ATTR   = 7'b0000010,
      PH_EXTENT = 7'b0000100,
      PH_PARENT = 7'b0001000,
      PH_NAME   = 7'b0010000,
      PH_PAD    = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  name_length;
      logic [7:0]  attribute_length;
      logic [31:0] extent_block;
      logic [15:0] parent_number;
      logic [15:0] record_number;
      logic [7:0]  name_char;
      logic [7:0]  name_position;
      logic        name_last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/ptrp_parser.sv
// record parsing state and per-byte result logic
`timescale 1ns / 1ps
`default_nettype none
`include "path_table_record_parser_core_defines.svh"

module ptrp_parser
   import ptrp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] table_byte,
   input  wire logic       table_start,
   output rsp_type         res,
   output logic            res_valid
);

   phase_type   phase_ff, phase_in, phase_eff;
   logic [1:0]  offset_ff, offset_in;
   logic [7:0]  ident_len_ff, ident_len_in;
   logic [7:0]  attr_len_ff, attr_len_in;
   logic [31:0] extent_ff, extent_in;
   logic [15:0] parent_ff, parent_in;
   logic [7:0]  name_count_ff, name_count_in;
   logic [15:0] records_ff, records_in, records_eff;
   logic        last;

   assign phase_eff   = table_start ? PH_LEN : phase_ff;
   assign records_eff = table_start ? 16'd0 : records_ff;
   assign last        = ({1'b0, name_count_ff} + 9'd1) >= {1'b0, ident_len_ff};

   always_comb begin
      phase_in      = phase_eff;
      offset_in     = offset_ff;
      ident_len_in  = ident_len_ff;
      attr_len_in   = attr_len_ff;
      extent_in     = extent_ff;
      parent_in     = parent_ff;
      name_count_in = name_count_ff;
      records_in    = records_eff;
      res_valid     = 1'b0;
      res                  = '0;
      res.name_length      = ident_len_ff;
      res.attribute_length = attr_len_ff;
      res.extent_block     = extent_ff;
      res.parent_number    = parent_ff;
      case (phase_eff)
         PH_LEN: begin
            if (table_byte == END_BYTE) begin
               res               = '0;
               res.result_kind   = KIND_END;
               res.record_number = records_eff;
               res_valid         = 1'b1;
               phase_in          = PH_DONE;
            end else begin
               ident_len_in  = table_byte;
               attr_len_in   = 8'd0;
               extent_in     = 32'd0;
               parent_in     = 16'd0;
               name_count_in = 8'd0;
               offset_in     = 2'd0;
               phase_in      = PH_ATTR;
            end
         end
         PH_ATTR: begin
            attr_len_in = table_byte;
            offset_in   = 2'd0;
            phase_in    = PH_EXTENT;
         end
         PH_EXTENT: begin
            extent_in = {extent_ff[23:0], table_byte};
            if (offset_ff == EXTENT_LAST) begin
               offset_in = 2'd0;
               phase_in  = PH_PARENT;
            end else begin
               offset_in = offset_ff + 2'd1;
            end
         end
         PH_PARENT: begin
            parent_in = {parent_ff[7:0], table_byte};
            if (offset_ff >= PARENT_LAST) begin
               offset_in          = 2'd0;
               res.result_kind    = KIND_HEADER;
               res.parent_number  = {parent_ff[7:0], table_byte};
               res.record_number  = records_ff;
               res_valid          = 1'b1;
               if (records_ff != COUNT_MAX) begin
                  records_in = records_ff + 16'd1;
               end
               name_count_in = 8'd0;
               phase_in      = PH_NAME;
            end else begin
               offset_in = offset_ff + 2'd1;
            end
         end
         PH_NAME: begin
            res.result_kind   = KIND_NAME;
            res.record_number = (records_ff == COUNT_MAX) ? COUNT_MAX
                                                          : records_ff - 16'd1;
            res.name_char     = table_byte;
            res.name_position = name_count_ff;
            res.name_last     = last;
            res_valid         = 1'b1;
            if (last) begin
               name_count_in = 8'd0;
               phase_in      = ident_len_ff[0] ? PH_PAD : PH_LEN;
            end else begin
               name_count_in = name_count_ff + 8'd1;
            end
         end
         PH_PAD: begin
            phase_in = PH_LEN;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         offset_ff     <= 2'd0;
         ident_len_ff  <= 8'd0;
         attr_len_ff   <= 8'd0;
         extent_ff     <= 32'd0;
         parent_ff     <= 16'd0;
         name_count_ff <= 8'd0;
         records_ff    <= 16'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         ident_len_ff  <= ident_len_in;
         attr_len_ff   <= attr_len_in;
         extent_ff     <= extent_in;
         parent_ff     <= parent_in;
         name_count_ff <= name_count_in;
         records_ff    <= records_in;
      end
   end

   // identifier position stays inside the identifier
   `PTRP_ASSERT(a_name_in_range, clock, reset,
      (phase_ff == PH_NAME) |-> (name_count_ff < ident_len_ff))

   // record count only moves up between table starts
   `PTRP_ASSERT(a_count_monotonic, clock, reset,
      !(accept && table_start) |=> (records_ff >= $past(records_ff)))

   // pad byte gives no result
   `PTRP_ASSERT(a_pad_silent, clock, reset,
      (accept && !table_start && phase_ff == PH_PAD) |-> !res_valid)

   // an end result always leaves the parser in the done phase
   `PTRP_ASSERT(a_end_to_done, clock, reset,
      (accept && res_valid && res.result_kind == KIND_END) |=> (phase_ff == PH_DONE))

endmodule

`default_nettype wire

FILE: hw/rtl/ptrp_out_reg.sv
// result register that holds a transaction until the consumer takes it
`timescale 1ns / 1ps
`default_nettype none

module ptrp_out_reg
   import ptrp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire logic    res_valid,
   input  wire rsp_type res,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   output logic         space
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      if (load) begin
         valid_in = res_valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res_valid) begin
         data_ff <= res;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/path_table_record_parser_core.sv
// top level of the big-endian path table record parser
`timescale 1ns / 1ps
`default_nettype none

// Takes one path table byte per transaction and returns at most one result per
// byte: a header when the last parent byte arrives, one result per identifier
// byte, and a count result on a zero length byte. One byte is accepted every
// cycle; its result shows on the rsp_ channel the cycle after acceptance from
// a single output register, and input is held off only while that register is
// full and not being taken. req_table_start restarts parsing with that byte.

module path_table_record_parser_core
   import ptrp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_table_byte,
   input  wire logic        req_table_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [7:0]       rsp_name_length,
   output logic [7:0]       rsp_attribute_length,
   output logic [31:0]      rsp_extent_block,
   output logic [15:0]      rsp_parent_number,
   output logic [15:0]      rsp_record_number,
   output logic [7:0]       rsp_name_char,
   output logic [7:0]       rsp_name_position,
   output logic             rsp_name_last
);

   logic    accept;
   logic    res_valid;
   rsp_type res;
   rsp_type rsp_data;

   assign accept = req_valid && req_ready;

   ptrp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .table_byte  (req_table_byte),
      .table_start (req_table_start),
      .res         (res),
      .res_valid   (res_valid)
   );

   ptrp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_valid (res_valid),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .space     (req_ready)
   );

   assign rsp_result_kind      = rsp_data.result_kind;
   assign rsp_name_length      = rsp_data.name_length;
   assign rsp_attribute_length = rsp_data.attribute_length;
   assign rsp_extent_block     = rsp_data.extent_block;
   assign rsp_parent_number    = rsp_data.parent_number;
   assign rsp_record_number    = rsp_data.record_number;
   assign rsp_name_char        = rsp_data.name_char;
   assign rsp_name_position    = rsp_data.name_position;
   assign rsp_name_last        = rsp_data.name_last;

endmodule

`default_nettype wire
